>>> sv/rbuv_pkg.sv
// Package: widths, constants, lane payload type and rounding/saturation helpers.
package rbuv_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int HALF      = 1 << (FRAC_BITS - 1);

	localparam int DW    = 16;          // port field width
	localparam int PRODW = 32;          // 16x16 product
	localparam int SUMW  = 34;          // cross / dot sum
	localparam int VW    = 19;          // rounded cross component
	localparam int CW    = 20;          // rounded dot product
	localparam int MFW   = 21;          // one - c before clamp
	localparam int MW    = 18;          // clamped m
	localparam int PW    = 36;          // vi*vj
	localparam int S2W   = 36;          // |v|^2
	localparam int NW    = 38;          // numerator term
	localparam int PNW   = 56;          // n*m
	localparam int NUMW  = 54;          // dividend magnitude
	localparam int QB    = 18;          // quotient bits, one per divider stage
	localparam int RW    = NUMW - QB + 1; // partial remainder
	localparam int EW    = 21;          // matrix entry before saturation
	localparam int LANES = 6;           // 00, 11, 22, 01, 02, 12

	// one divider pipeline beat
	typedef struct packed {
		logic [2:0][VW-1:0]       v;
		logic                     zero;
		logic                     ok;
		logic [S2W-1:0]           s2;
		logic [LANES-1:0]         neg;
		logic [LANES-1:0][RW-1:0] rem;
		logic [LANES-1:0][QB-1:0] nlo;
		logic [LANES-1:0][QB-1:0] quo;
	} div_pl_t;

	// round a Q.2F sum to Q.F, half away from zero
	function automatic logic signed [CW-1:0] round_frac(input logic signed [SUMW-1:0] x);
		logic [SUMW-1:0] mag;
		logic [SUMW-1:0] r;
		mag = x[SUMW-1] ? SUMW'(-x) : SUMW'(x);
		r = (mag + SUMW'(HALF)) >> FRAC_BITS;
		round_frac = x[SUMW-1] ? -$signed(CW'(r)) : $signed(CW'(r));
	endfunction

	// clamp to [-one, one]
	function automatic logic [DW-1:0] sat_one(input logic signed [EW-1:0] x);
		if (x > EW'(ONE))
			sat_one = DW'(ONE);
		else if (x < -EW'(ONE))
			sat_one = DW'(-ONE);
		else
			sat_one = DW'(x);
	endfunction

endpackage

>>> sv/rbuv_if.sv
// Channel interfaces: vector pair in, rotation matrix out.
interface rbuv_vec_if;
	logic                valid;
	logic                ready;
	logic signed [15:0]  from_x;
	logic signed [15:0]  from_y;
	logic signed [15:0]  from_z;
	logic signed [15:0]  to_x;
	logic signed [15:0]  to_y;
	logic signed [15:0]  to_z;

	modport source(output valid, from_x, from_y, from_z, to_x, to_y, to_z, input ready);
	modport sink(input valid, from_x, from_y, from_z, to_x, to_y, to_z, output ready);
endinterface

interface rbuv_rot_if;
	logic                valid;
	logic                ready;
	logic signed [15:0]  r00;
	logic signed [15:0]  r01;
	logic signed [15:0]  r02;
	logic signed [15:0]  r10;
	logic signed [15:0]  r11;
	logic signed [15:0]  r12;
	logic signed [15:0]  r20;
	logic signed [15:0]  r21;
	logic signed [15:0]  r22;
	logic                valid_res;

	modport source(output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, valid_res,
		input ready);
	modport sink(input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, valid_res,
		output ready);
endinterface

>>> sv/rotation_between_unit_vectors.sv
// Pipeline: 7 arithmetic stages, 18 divider steps and an output register from accepted pair to result beat.
// Throughput: one pair per cycle when not stalled; divider fully pipelined, one quotient bit per stage.
// Each stage holds or advances on its own, so bubbles close up behind a stalled output.
// Reset (arst_n low, asynchronous) clears every stage valid bit; data registers are not reset.
// Result is the Rodrigues rotation taking the source vector onto the target, entries saturated to +-1.
module rotation_between_unit_vectors (
	input  logic clk,
	input  logic arst_n,
	rbuv_vec_if.sink   vecs,
	rbuv_rot_if.source rot
);
	import rbuv_pkg::*;

	localparam int NFRONT = 7;
	localparam int NST    = NFRONT + QB + 1;
	localparam int LA [LANES] = '{0, 1, 2, 0, 0, 1};
	localparam int LB [LANES] = '{0, 1, 2, 1, 2, 2};

	logic [NST:1] vld_q;
	logic [NST:1] en;

	// stage handshake: advance when empty or when the next stage advances
	always_comb begin
		en[NST] = !vld_q[NST] || rot.ready;
		for (int i = NST - 1; i >= 1; i--)
			en[i] = !vld_q[i] || en[i+1];
	end

	assign vecs.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= vecs.valid;
			for (int i = 2; i <= NST; i++)
				if (en[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	// s1: raw products
	logic signed [PRODW-1:0] prod_s1 [9];
	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s1[0] <= vecs.from_y * vecs.to_z;
			prod_s1[1] <= vecs.from_z * vecs.to_y;
			prod_s1[2] <= vecs.from_z * vecs.to_x;
			prod_s1[3] <= vecs.from_x * vecs.to_z;
			prod_s1[4] <= vecs.from_x * vecs.to_y;
			prod_s1[5] <= vecs.from_y * vecs.to_x;
			prod_s1[6] <= vecs.from_x * vecs.to_x;
			prod_s1[7] <= vecs.from_y * vecs.to_y;
			prod_s1[8] <= vecs.from_z * vecs.to_z;
		end
	end

	// s2: cross and dot, rounded to Q.F
	logic signed [VW-1:0] v_s2 [3];
	logic signed [CW-1:0] c_s2;
	always_ff @(posedge clk) begin
		if (en[2]) begin
			v_s2[0] <= VW'(round_frac(SUMW'(prod_s1[0]) - SUMW'(prod_s1[1])));
			v_s2[1] <= VW'(round_frac(SUMW'(prod_s1[2]) - SUMW'(prod_s1[3])));
			v_s2[2] <= VW'(round_frac(SUMW'(prod_s1[4]) - SUMW'(prod_s1[5])));
			c_s2    <= round_frac(SUMW'(prod_s1[6]) + SUMW'(prod_s1[7]) + SUMW'(prod_s1[8]));
		end
	end

	// s3: pairwise products of v, clamped m = one - c
	logic signed [MFW-1:0] m_full;
	logic signed [MW-1:0]  m_clamp;
	always_comb begin
		m_full = MFW'(ONE) - MFW'(c_s2);
		if (m_full > MFW'(4 * ONE))
			m_clamp = MW'(4 * ONE);
		else if (m_full < -MFW'(4 * ONE))
			m_clamp = MW'(-4 * ONE);
		else
			m_clamp = MW'(m_full);
	end

	logic signed [PW-1:0] sq_s3 [LANES];
	logic signed [VW-1:0] v_s3 [3];
	logic signed [MW-1:0] m_s3;
	logic                 cpos_s3;
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int l = 0; l < LANES; l++)
				sq_s3[l] <= v_s2[LA[l]] * v_s2[LB[l]];
			v_s3    <= v_s2;
			m_s3    <= m_clamp;
			cpos_s3 <= c_s2 > 0;
		end
	end

	// s4: |v|^2
	logic signed [PW-1:0] sq_s4 [LANES];
	logic signed [VW-1:0] v_s4 [3];
	logic signed [MW-1:0] m_s4;
	logic                 cpos_s4;
	logic [S2W-1:0]       s2_s4;
	always_ff @(posedge clk) begin
		if (en[4]) begin
			sq_s4   <= sq_s3;
			v_s4    <= v_s3;
			m_s4    <= m_s3;
			cpos_s4 <= cpos_s3;
			s2_s4   <= S2W'(sq_s3[0] + sq_s3[1] + sq_s3[2]);
		end
	end

	// s5: numerators, diagonal lanes take off |v|^2
	logic signed [NW-1:0] n_s5 [LANES];
	logic signed [VW-1:0] v_s5 [3];
	logic signed [MW-1:0] m_s5;
	logic [S2W-1:0]       s2_s5;
	logic                 zero_s5;
	logic                 ok_s5;
	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int l = 0; l < LANES; l++)
				n_s5[l] <= (l < 3) ? NW'(sq_s4[l]) - $signed({2'b00, s2_s4}) : NW'(sq_s4[l]);
			v_s5    <= v_s4;
			m_s5    <= m_s4;
			s2_s5   <= s2_s4;
			zero_s5 <= s2_s4 == '0;
			ok_s5   <= cpos_s4;
		end
	end

	// s6: n * m
	logic signed [PNW-1:0] p_s6 [LANES];
	logic signed [VW-1:0]  v_s6 [3];
	logic [S2W-1:0]        s2_s6;
	logic                  zero_s6;
	logic                  ok_s6;
	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int l = 0; l < LANES; l++)
				p_s6[l] <= n_s5[l] * m_s5;
			v_s6    <= v_s5;
			s2_s6   <= s2_s5;
			zero_s6 <= zero_s5;
			ok_s6   <= ok_s5;
		end
	end

	// s7: dividend magnitude plus half divisor, load divider beat
	div_pl_t              div_pl [QB+1];
	div_pl_t              div_ld;
	logic [PNW-1:0]       pmag [LANES];
	logic [NUMW-1:0]      num [LANES];
	always_comb begin
		div_ld.zero = zero_s6;
		div_ld.ok   = ok_s6;
		div_ld.s2   = s2_s6;
		for (int i = 0; i < 3; i++)
			div_ld.v[i] = v_s6[i];
		for (int l = 0; l < LANES; l++) begin
			pmag[l]          = p_s6[l][PNW-1] ? PNW'(-p_s6[l]) : PNW'(p_s6[l]);
			num[l]           = NUMW'(pmag[l]) + NUMW'(s2_s6 >> 1);
			div_ld.neg[l]    = p_s6[l][PNW-1];
			div_ld.rem[l]    = RW'(num[l][NUMW-1:QB]);
			div_ld.nlo[l]    = num[l][QB-1:0];
			div_ld.quo[l]    = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[NFRONT])
			div_pl[0] <= div_ld;
	end

	// divider: one quotient bit per stage
	for (genvar k = 0; k < QB; k++) begin : g_div
		rbuv_div_step u_step (
			.clk (clk),
			.en  (en[NFRONT+1+k]),
			.d   (div_pl[k]),
			.q   (div_pl[k+1])
		);
	end

	// output stage: assemble I + K + term, saturate, special cases
	div_pl_t              dq;
	logic signed [EW-1:0] t [LANES];
	logic signed [EW-1:0] vx, vy, vz;
	logic [8:0][DW-1:0]   ent;
	logic                 res_ok;
	always_comb begin
		dq = div_pl[QB];
		for (int l = 0; l < LANES; l++)
			t[l] = dq.neg[l] ? -$signed(EW'(dq.quo[l])) : $signed(EW'(dq.quo[l]));
		vx = EW'($signed(dq.v[0]));
		vy = EW'($signed(dq.v[1]));
		vz = EW'($signed(dq.v[2]));
		ent[0] = sat_one(EW'(ONE) + t[0]);
		ent[1] = sat_one(-vz + t[3]);
		ent[2] = sat_one(vy + t[4]);
		ent[3] = sat_one(vz + t[3]);
		ent[4] = sat_one(EW'(ONE) + t[1]);
		ent[5] = sat_one(-vx + t[5]);
		ent[6] = sat_one(-vy + t[4]);
		ent[7] = sat_one(vx + t[5]);
		ent[8] = sat_one(EW'(ONE) + t[2]);
		res_ok = 1'b1;
		if (dq.zero) begin
			res_ok = dq.ok;
			for (int e = 0; e < 9; e++)
				ent[e] = (dq.ok && (e == 0 || e == 4 || e == 8)) ? DW'(ONE) : '0;
		end
	end

	logic [8:0][DW-1:0] ent_q;
	logic               ok_q;
	always_ff @(posedge clk) begin
		if (en[NST]) begin
			ent_q <= ent;
			ok_q  <= res_ok;
		end
	end

	assign rot.valid     = vld_q[NST];
	assign rot.r00       = ent_q[0];
	assign rot.r01       = ent_q[1];
	assign rot.r02       = ent_q[2];
	assign rot.r10       = ent_q[3];
	assign rot.r11       = ent_q[4];
	assign rot.r12       = ent_q[5];
	assign rot.r20       = ent_q[6];
	assign rot.r21       = ent_q[7];
	assign rot.r22       = ent_q[8];
	assign rot.valid_res = ok_q;

endmodule

>>> sv/rbuv_div_step.sv
// One registered restoring-division step for all six lanes: one quotient bit per lane.
module rbuv_div_step (
	input  logic              clk,
	input  logic              en,
	input  rbuv_pkg::div_pl_t d,
	output rbuv_pkg::div_pl_t q
);
	import rbuv_pkg::*;

	div_pl_t nxt;
	logic [RW-1:0] trial [LANES];

	// shift in next dividend bit, subtract divisor when it fits
	always_comb begin
		nxt = d;
		for (int l = 0; l < LANES; l++) begin
			trial[l] = {d.rem[l][RW-2:0], d.nlo[l][QB-1]};
			nxt.nlo[l] = {d.nlo[l][QB-2:0], 1'b0};
			if (trial[l] >= RW'(d.s2)) begin
				nxt.rem[l] = trial[l] - RW'(d.s2);
				nxt.quo[l] = {d.quo[l][QB-2:0], 1'b1};
			end else begin
				nxt.rem[l] = trial[l];
				nxt.quo[l] = {d.quo[l][QB-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			q <= nxt;
	end

endmodule

>>> tb/sv/rbuv_checker.sv
// Checker: predicts each rotation from accepted vector pairs and compares result beats.
`timescale 1ns / 1ps
module rbuv_checker (
	input  logic       clk,
	input  logic       arst_n,
	rbuv_vec_if        vecs,
	rbuv_rot_if        rot,
	output int         fail_count,
	output int         pending,
	output int         result_count
);
	typedef struct {
		logic signed [15:0] r [9];
		logic               ok;
	} rot_t;

	rot_t rot_q [$];
	int   mismatch_count;

	function automatic longint rnd_div(longint n, longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	// Rodrigues rotation in exact integer arithmetic
	function automatic rot_t predict_rot(longint fx, longint fy, longint fz,
		longint tx, longint ty, longint tz);
		rot_t   res;
		longint one, c, s2, m, n, t, e;
		longint v [3];
		longint k [3][3];
		one = 1 << rbuv_pkg::FRAC_BITS;
		v[0] = rnd_div(fy * tz - fz * ty, one);
		v[1] = rnd_div(fz * tx - fx * tz, one);
		v[2] = rnd_div(fx * ty - fy * tx, one);
		c = rnd_div(fx * tx + fy * ty + fz * tz, one);
		s2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
		if (s2 == 0) begin
			// parallel gives identity; opposite (or a zero vector) gives an all-zero matrix flagged not ok
			res.ok = (c > 0);
			for (int i = 0; i < 9; i++)
				res.r[i] = (res.ok && (i % 4 == 0)) ? 16'(one) : 16'sd0;
			return res;
		end
		m = one - c;
		if (m > 4 * one) m = 4 * one;
		if (m < -4 * one) m = -4 * one;
		k[0][0] = 0;     k[0][1] = -v[2]; k[0][2] = v[1];
		k[1][0] = v[2];  k[1][1] = 0;     k[1][2] = -v[0];
		k[2][0] = -v[1]; k[2][1] = v[0];  k[2][2] = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				n = v[i] * v[j] - ((i == j) ? s2 : 0);
				t = rnd_div(n * m, s2);
				e = ((i == j) ? one : 0) + k[i][j] + t;
				if (e > one) e = one;
				if (e < -one) e = -one;
				res.r[i * 3 + j] = 16'(e);
			end
		res.ok = 1'b1;
		return res;
	endfunction

	assign pending = rot_q.size();

	always @(posedge clk or negedge arst_n) begin
		rot_t exp_rot;
		logic signed [15:0] got [9];
		logic bad;
		if (!arst_n) begin
			rot_q.delete();
			fail_count <= 0;
			mismatch_count = 0;
			result_count <= 0;
		end else begin
			if (vecs.valid && vecs.ready)
				rot_q.push_back(predict_rot(vecs.from_x, vecs.from_y, vecs.from_z,
					vecs.to_x, vecs.to_y, vecs.to_z));
			if (rot.valid && rot.ready) begin
				result_count <= result_count + 1;
				got = '{rot.r00, rot.r01, rot.r02, rot.r10, rot.r11, rot.r12,
					rot.r20, rot.r21, rot.r22};
				if (rot_q.size() == 0) begin
					fail_count <= fail_count + 1;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result beat at %0t", $realtime);
				end else begin
					exp_rot = rot_q.pop_front();
					bad = (exp_rot.ok !== rot.valid_res);
					for (int i = 0; i < 9; i++)
						if (exp_rot.r[i] !== got[i]) bad = 1'b1;
					if (bad) begin
						fail_count <= fail_count + 1;
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch at %0t: exp %p ok %0b, got %p ok %0b",
								$realtime, exp_rot.r, exp_rot.ok, got, rot.valid_res);
					end
				end
			end
		end
	end
endmodule

>>> tb/sv/tb_top.sv
// Testbench top: drives vector pairs, stalls the result side and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
	import rbuv_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count, pending, result_count;
	int   sent;
	bit   calm;

	rbuv_vec_if vecs ();
	rbuv_rot_if rot ();

	rotation_between_unit_vectors i_dut (.clk(clk), .arst_n(arst_n), .vecs(vecs), .rot(rot));
	rbuv_checker i_chk (.clk(clk), .arst_n(arst_n), .vecs(vecs), .rot(rot),
		.fail_count(fail_count), .pending(pending), .result_count(result_count));

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// result-side stalls in bursts
	initial begin
		int n;
		rot.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 18);
				rot.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			rot.ready <= 1'b1;
		end
	end

	// random unit-ish vector component, Q1.14
	function automatic logic signed [15:0] pick_comp();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			3: return 16'($signed($urandom_range(0, 32768)) - 16384);
			4: return 16'($signed($urandom_range(0, 40)) - 20);
			default: return 16'($signed($urandom_range(0, 65535)));
		endcase
	endfunction

	task automatic send_pair(int fx, fy, fz, tx, ty, tz);
		int n;
		if (!calm && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 18);
			vecs.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		vecs.valid <= 1'b1;
		vecs.from_x <= 16'(fx); vecs.from_y <= 16'(fy); vecs.from_z <= 16'(fz);
		vecs.to_x <= 16'(tx); vecs.to_y <= 16'(ty); vecs.to_z <= 16'(tz);
		@(posedge clk);
		while (!vecs.ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	initial begin
		logic signed [15:0] a, b, c;
		vecs.valid = 1'b0;
		{vecs.from_x, vecs.from_y, vecs.from_z} = '0;
		{vecs.to_x, vecs.to_y, vecs.to_z} = '0;
		calm = 1'b0;
		sent = 0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// directed: parallel, opposite, axis turns, extremes, zero and raw bits
		send_pair(16384, 0, 0, 16384, 0, 0);
		send_pair(0, 16384, 0, 0, 16384, 0);
		send_pair(16384, 0, 0, -16384, 0, 0);
		send_pair(0, 0, -16384, 0, 0, 16384);
		send_pair(16384, 0, 0, 0, 16384, 0);
		send_pair(0, 16384, 0, 0, 0, 16384);
		send_pair(0, 0, 16384, 16384, 0, 0);
		send_pair(-16384, -16384, -16384, 16384, 16384, 16384);
		send_pair(-16384, 16384, -16384, 16384, -16384, 16384);
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(0, 0, 0, 16384, 0, 0);
		send_pair(11585, 11585, 0, 11585, -11585, 0);
		send_pair(16384, 1, 0, 16384, 0, 0);
		send_pair(16384, 0, 0, -16384, 1, 0);
		send_pair(-1, -1, -1, -1, -1, -1);
		send_pair(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
		send_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_pair(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
		send_pair(9459, 9459, 9459, 9459, 9459, -9459);
		// random pairs; some parallel and some opposite
		for (int i = 0; i < 600; i++) begin
			if (i >= 520) calm = 1'b1;
			a = pick_comp(); b = pick_comp(); c = pick_comp();
			case ($urandom_range(0, 3))
				0: send_pair(a, b, c, a, b, c);
				1: send_pair(a, b, c, -a, -b, -c);
				default: send_pair(a, b, c, pick_comp(), pick_comp(), pick_comp());
			endcase
		end
		vecs.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("sent %0d vector pairs, %0d rotation beats checked", sent, result_count);
		$display("covered parallel, opposite, axis, extreme and random pairs with stalls");
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout");
		$display("tb_top NOT OK");
		$finish;
	end
endmodule

>>> filelist.f
sv/rbuv_pkg.sv
sv/rbuv_if.sv
sv/rbuv_div_step.sv
sv/rotation_between_unit_vectors.sv
tb/sv/rbuv_checker.sv
tb/sv/tb_top.sv
